>>> rtl/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg: shared types and constants
// Widths, opcodes, register indexes and sequencer states for the
// difference-constraint feasibility unit.
// ----------------------------------------------------------------------------
package dcf_pkg;

    localparam int MaxVars   = 64;
    localparam int MaxCons   = 256;
    localparam int IdxW      = 6;
    localparam int AddrW     = 8;
    localparam int CountW    = 9;
    localparam int VarCntW   = 7;
    localparam int BoundW    = 32;
    localparam int MagW      = 33;
    localparam int DistW     = 48;
    localparam int EntryW    = 2 * IdxW + BoundW;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic REG_VAR_COUNT = 1'b0;
    localparam logic REG_ENUM_CAP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_BOX,
        ST_READ,
        ST_FETCH,
        ST_RELAX,
        ST_DONE
    } state_t;

endpackage

>>> rtl/difference_constraint_feasibility_unit.sv
// ----------------------------------------------------------------------------
// difference_constraint_feasibility_unit: negative-cycle check on constraints
// Stores difference constraints and, on an evaluate request, runs a
// Bellman-Ford sweep with one shared add/compare unit, then reports
// feasibility and whether the saturated box size is within the cap.
// ----------------------------------------------------------------------------
// channel     dir   fields
// s_axis      in    tuser: operation; tdata: left_index, right_index, bound
// m_axis      out   tdata: feasible, used_enumeration
// cfg         in    wr_en, wr_index, wr_data (var_count, enumeration_cap)
//
// add request: accepted back to back.
// evaluate: an accept step, a clear of the distance table, the box-multiply steps
//   and up to n+1 passes with a store read, distance read and relax step per stored
//   constraint, then the result is held until taken.
// the store and the distance table are read through registers before each relax step.
// rst_n clears control, count, magnitude, var_count, loads cap 1000000, keeps store.
// s_axis_tready is low from an evaluate request until its result is taken.
// ----------------------------------------------------------------------------
module difference_constraint_feasibility_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // left_index, right_index, bound, pad
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // feasible, used_enumeration, pad
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data
);

    dcf_pkg::state_t state_reg, state_next;

    logic [dcf_pkg::VarCntW-1:0] var_count_reg;
    logic [31:0]                 cap_reg;
    logic [dcf_pkg::CountW-1:0]  count_reg;
    logic [dcf_pkg::MagW-1:0]    mag_reg;

    logic [dcf_pkg::EntryW-1:0]  store_mem [dcf_pkg::MaxCons];
    logic [dcf_pkg::EntryW-1:0]  entry_reg;
    logic [dcf_pkg::DistW-1:0]   dist_reg [dcf_pkg::MaxVars];
    logic signed [dcf_pkg::DistW-1:0] dist_l_reg;
    logic signed [dcf_pkg::DistW-1:0] dist_r_reg;

    logic [dcf_pkg::CountW-1:0]  k_reg;
    logic [dcf_pkg::VarCntW-1:0] round_reg;
    logic [dcf_pkg::IdxW:0]      clr_reg;
    logic [dcf_pkg::VarCntW-1:0] n_reg;
    logic [dcf_pkg::VarCntW-1:0] box_i_reg;
    logic [40:0]                 base_reg;
    logic [32:0]                 combos_reg;
    logic                        neg_reg;
    logic                        feas_reg;
    logic                        small_reg;
    logic                        out_valid_reg;

    logic                        in_go;
    logic                        op;
    logic [dcf_pkg::IdxW-1:0]    in_left;
    logic [dcf_pkg::IdxW-1:0]    in_right;
    logic [dcf_pkg::BoundW-1:0]  in_bound;
    logic [dcf_pkg::MagW-1:0]    in_mag;

    logic [dcf_pkg::IdxW-1:0]    e_left;
    logic [dcf_pkg::IdxW-1:0]    e_right;
    logic signed [dcf_pkg::DistW-1:0] e_bound;
    logic signed [dcf_pkg::DistW-1:0] cand;
    logic                        in_range;
    logic                        relaxable;
    logic                        last_k;
    logic                        last_round;
    logic [63:0]                 product;
    logic                        base_big;
    logic                        box_over;
    logic                        box_end;

    assign op       = s_axis_tuser;
    assign in_left  = s_axis_tdata[5:0];
    assign in_right = s_axis_tdata[11:6];
    assign in_bound = s_axis_tdata[43:12];
    assign in_mag   = in_bound[31] ? (dcf_pkg::MagW'(0) - {1'b1, in_bound})
                                   : {1'b0, in_bound};
    assign in_go    = s_axis_tvalid && s_axis_tready;

    assign e_left   = entry_reg[5:0];
    assign e_right  = entry_reg[11:6];
    assign e_bound  = dcf_pkg::DistW'(signed'(entry_reg[43:12]));
    assign in_range = ({1'b0, e_left} < n_reg) && ({1'b0, e_right} < n_reg);
    assign cand     = dist_r_reg + e_bound;
    assign relaxable = in_range && (dist_l_reg > cand);
    assign last_k   = (k_reg + 1'b1) >= count_reg;
    assign last_round = round_reg >= n_reg;

    // box: combos <= cap tracked with saturation at cap + 1
    // a base above cap overflows at once, else both factors fit in 32 bits
    assign base_big = base_reg > 41'(cap_reg);
    assign product  = {32'd0, combos_reg[31:0]} * {32'd0, base_reg[31:0]};
    assign box_over = base_big || (product > {32'd0, cap_reg});
    assign box_end  = (box_i_reg >= n_reg) || (combos_reg > {1'b0, cap_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dcf_pkg::ST_IDLE:  if (in_go && op == dcf_pkg::OP_EVAL)
                                   state_next = dcf_pkg::ST_CLEAR;
            dcf_pkg::ST_CLEAR: if (clr_reg[dcf_pkg::IdxW]) state_next = dcf_pkg::ST_BOX;
            dcf_pkg::ST_BOX:   if (box_end)
                                   state_next = (count_reg == '0) ? dcf_pkg::ST_DONE
                                                                  : dcf_pkg::ST_READ;
            dcf_pkg::ST_READ:  state_next = dcf_pkg::ST_FETCH;
            dcf_pkg::ST_FETCH: state_next = dcf_pkg::ST_RELAX;
            dcf_pkg::ST_RELAX:
            begin
                if (last_round && relaxable)
                    state_next = dcf_pkg::ST_DONE;
                else if (last_k && last_round)
                    state_next = dcf_pkg::ST_DONE;
                else
                    state_next = dcf_pkg::ST_READ;
            end
            dcf_pkg::ST_DONE:  if (m_axis_tready) state_next = dcf_pkg::ST_IDLE;
            default:           state_next = dcf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == dcf_pkg::ST_IDLE);
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = {6'b0, small_reg, feas_reg};
    end

    always_ff @(posedge clk)
    begin
        if (in_go && op == dcf_pkg::OP_ADD && count_reg < dcf_pkg::CountW'(dcf_pkg::MaxCons))
            store_mem[count_reg[dcf_pkg::AddrW-1:0]] <= {in_bound, in_right, in_left};
        if (state_reg == dcf_pkg::ST_READ || state_reg == dcf_pkg::ST_BOX)
            entry_reg <= store_mem[k_reg[dcf_pkg::AddrW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == dcf_pkg::ST_CLEAR && !clr_reg[dcf_pkg::IdxW])
            dist_reg[clr_reg[dcf_pkg::IdxW-1:0]] <= '0;
        else if (state_reg == dcf_pkg::ST_RELAX && relaxable && !last_round)
            dist_reg[e_left] <= cand;
        if (state_reg == dcf_pkg::ST_FETCH)
        begin
            dist_l_reg <= dist_reg[e_left];
            dist_r_reg <= dist_reg[e_right];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dcf_pkg::ST_IDLE;
            var_count_reg <= '0;
            cap_reg       <= 32'd1000000;
            count_reg     <= '0;
            mag_reg       <= '0;
            k_reg         <= '0;
            round_reg     <= '0;
            clr_reg       <= '0;
            n_reg         <= '0;
            box_i_reg     <= '0;
            base_reg      <= '0;
            combos_reg    <= '0;
            neg_reg       <= 1'b0;
            feas_reg      <= 1'b0;
            small_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                if (wr_index == dcf_pkg::REG_VAR_COUNT)
                    var_count_reg <= wr_data[dcf_pkg::VarCntW-1:0];
                else
                    cap_reg <= wr_data;
            end
            case (state_reg)
                dcf_pkg::ST_IDLE:
                begin
                    if (in_go && op == dcf_pkg::OP_ADD
                        && count_reg < dcf_pkg::CountW'(dcf_pkg::MaxCons))
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (in_mag > mag_reg)
                            mag_reg <= in_mag;
                    end
                    if (in_go && op == dcf_pkg::OP_EVAL)
                    begin
                        n_reg      <= (var_count_reg > dcf_pkg::VarCntW'(dcf_pkg::MaxVars))
                                      ? dcf_pkg::VarCntW'(dcf_pkg::MaxVars) : var_count_reg;
                        clr_reg    <= '0;
                        neg_reg    <= 1'b0;
                    end
                end
                dcf_pkg::ST_CLEAR:
                begin
                    clr_reg    <= clr_reg + 1'b1;
                    box_i_reg  <= '0;
                    combos_reg <= 33'd1;
                    base_reg   <= 41'((n_reg == '0) ? 7'd0 : n_reg - 1'b1) * 41'(mag_reg)
                                  + 41'd1;
                    k_reg      <= '0;
                    round_reg  <= '0;
                end
                dcf_pkg::ST_BOX:
                begin
                    if (!box_end)
                    begin
                        box_i_reg  <= box_i_reg + 1'b1;
                        combos_reg <= box_over ? ({1'b0, cap_reg} + 33'd1) : product[32:0];
                    end
                    else
                        small_reg <= combos_reg <= {1'b0, cap_reg};
                end
                dcf_pkg::ST_RELAX:
                begin
                    if (last_round && relaxable)
                        neg_reg <= 1'b1;
                    if (last_k)
                    begin
                        k_reg     <= '0;
                        round_reg <= round_reg + 1'b1;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                dcf_pkg::ST_DONE:
                begin
                    if (m_axis_tready)
                        out_valid_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
            if (state_reg != dcf_pkg::ST_DONE && state_next == dcf_pkg::ST_DONE)
            begin
                out_valid_reg <= 1'b1;
                feas_reg  <= !(state_reg == dcf_pkg::ST_RELAX && last_round && relaxable)
                             && !neg_reg;
                count_reg <= '0;
                mag_reg   <= '0;
            end
        end
    end

    a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid == (state_reg == dcf_pkg::ST_DONE))
        else $error("result valid out of step with sequencer");
    a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while result pending");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dcf_pkg::CountW'(dcf_pkg::MaxCons))
        else $error("constraint count overflow");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: difference-constraint feasibility unit testbench
// Streams add and evaluate requests with random gaps, predicts every verdict
// with a Bellman-Ford sweep and box-size check of its own, and compares each
// result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic feasible;
        logic used_enum;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        wr_en;
    logic        wr_index;
    logic [31:0] wr_data;

    difference_constraint_feasibility_unit dut (.*);

    // predictor state
    logic [6:0]                  var_count_q;
    logic [31:0]                 enum_cap_q;
    logic [dcf_pkg::IdxW-1:0]    store_left [dcf_pkg::MaxCons];
    logic [dcf_pkg::IdxW-1:0]    store_right [dcf_pkg::MaxCons];
    longint                      store_bound [dcf_pkg::MaxCons];
    int                          cons_count;
    longint unsigned             largest_mag;

    verdict_t   verdicts_due[$];
    int         failures;
    int         send_idle_off;
    int         recv_idle_off;
    int         hold_cycles;
    int         items_sent;
    longint     cycle_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic void store_constraint(logic [dcf_pkg::IdxW-1:0] l,
                                             logic [dcf_pkg::IdxW-1:0] r,
                                             logic [31:0] b);
        longint          bv;
        longint unsigned mag;
        bv = longint'($signed(b));
        if (cons_count >= dcf_pkg::MaxCons)
            return;
        store_left[cons_count]  = l;
        store_right[cons_count] = r;
        store_bound[cons_count] = bv;
        cons_count++;
        mag = (bv < 0) ? longint'(-bv) : bv;
        if (mag > largest_mag)
            largest_mag = mag;
    endfunction

    function automatic verdict_t evaluate_store();
        verdict_t        v;
        int              n;
        longint unsigned cap;
        longint unsigned base;
        longint unsigned combos;
        longint          dtab [dcf_pkg::MaxVars];
        longint          cand;
        int              a;
        int              b;
        n = (var_count_q > dcf_pkg::MaxVars) ? dcf_pkg::MaxVars : int'(var_count_q);
        cap = 64'(enum_cap_q);
        base = longint'(n > 0 ? n - 1 : 0) * largest_mag + 1;
        combos = 1;
        for (int i = 0; i < n && combos <= cap; i++)
        begin
            if (combos > cap / base)
                combos = cap + 1;
            else
                combos = combos * base;
        end
        v.used_enum = (combos <= cap);
        for (int k = 0; k < dcf_pkg::MaxVars; k++)
            dtab[k] = 0;
        for (int rd = 0; rd < n; rd++)
            for (int k = 0; k < cons_count; k++)
            begin
                a = int'(store_left[k]);
                b = int'(store_right[k]);
                if (a < n && b < n)
                begin
                    cand = dtab[b] + store_bound[k];
                    if (dtab[a] > cand)
                        dtab[a] = cand;
                end
            end
        v.feasible = 1'b1;
        for (int k = 0; k < cons_count; k++)
        begin
            a = int'(store_left[k]);
            b = int'(store_right[k]);
            if (a < n && b < n && dtab[a] > dtab[b] + store_bound[k])
                v.feasible = 1'b0;
        end
        cons_count = 0;
        largest_mag = 0;
        return v;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t unexpected result %b", $time, m_axis_tdata[1:0]);
                failures++;
            end
            else
            begin
                exp_v = verdicts_due.pop_front();
                if (m_axis_tdata[0] !== exp_v.feasible)
                begin
                    $display("%0t feasible: expected %b actual %b", $time,
                             exp_v.feasible, m_axis_tdata[0]);
                    failures++;
                end
                if (m_axis_tdata[1] !== exp_v.used_enum)
                begin
                    $display("%0t used_enumeration: expected %b actual %b", $time,
                             exp_v.used_enum, m_axis_tdata[1]);
                    failures++;
                end
            end
        end
    end

    // receiver
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                while (hold_cycles > 0)
                begin
                    @(negedge clk);
                    hold_cycles--;
                end
            end
            gap = recv_idle_off ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_request(logic op, logic [dcf_pkg::IdxW-1:0] l,
                                logic [dcf_pkg::IdxW-1:0] r, logic [31:0] b);
        int       gap;
        verdict_t v;
        gap = send_idle_off ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, b, r, l};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (op == dcf_pkg::OP_ADD)
            store_constraint(l, r, b);
        else
        begin
            v = evaluate_store();
            verdicts_due = {verdicts_due, v};
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        if (idx == dcf_pkg::REG_VAR_COUNT)
            var_count_q = val[6:0];
        else
            enum_cap_q = val;
    endtask

    task automatic configure(logic [6:0] n, logic [31:0] cap);
        wait_drained();
        write_reg(dcf_pkg::REG_VAR_COUNT, {25'd0, n});
        write_reg(dcf_pkg::REG_ENUM_CAP, cap);
        wr_en <= 1'b0;
    endtask

    task automatic test_reset_values();
        // defaults: no variables, cap 1000000
        send_request(dcf_pkg::OP_ADD, 6'd0, 6'd1, 32'h7fffffff);
        send_request(dcf_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0);
        send_request(dcf_pkg::OP_EVAL, 6'h3f, 6'h3f, 32'hffffffff);
    endtask

    task automatic test_directed();
        configure(7'd3, 32'd0);
        // negative cycle 0 -> 1 -> 0
        send_request(dcf_pkg::OP_ADD, 6'd0, 6'd1, 32'd2);
        send_request(dcf_pkg::OP_ADD, 6'd1, 6'd0, 32'hfffffffd);
        send_request(dcf_pkg::OP_EVAL, 6'h2a, 6'h15, 32'h5555aaaa);
        // index out of range still counts toward magnitude
        send_request(dcf_pkg::OP_ADD, 6'd0, 6'd5, 32'h80000000);
        send_request(dcf_pkg::OP_ADD, 6'h3f, 6'd0, 32'd1);
        send_request(dcf_pkg::OP_ADD, 6'd2, 6'd1, 32'd0);
        send_request(dcf_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0);
        configure(7'd0, 32'd0);
        send_request(dcf_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0);
        configure(7'd127, 32'hffffffff);
        send_request(dcf_pkg::OP_ADD, 6'd63, 6'd62, 32'hffffffff);
        send_request(dcf_pkg::OP_ADD, 6'd62, 6'd63, 32'd1);
        send_request(dcf_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0);
        configure(7'd2, 32'd1000000);
        send_request(dcf_pkg::OP_ADD, 6'd1, 6'd0, 32'd999);
        send_request(dcf_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0);
        configure(7'd1, 32'd1);
        send_request(dcf_pkg::OP_ADD, 6'd0, 6'd0, 32'hffffffff);
        send_request(dcf_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0);
    endtask

    task automatic test_store_full();
        configure(7'd64, 32'd200);
        for (int i = 0; i < dcf_pkg::MaxCons; i++)
            send_request(dcf_pkg::OP_ADD, 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)), 32'($urandom_range(0, 3)));
        // ignored: neither stored nor counted in the magnitude
        send_request(dcf_pkg::OP_ADD, 6'd0, 6'd1, 32'h80000000);
        send_request(dcf_pkg::OP_ADD, 6'd1, 6'd0, 32'h80000000);
        send_request(dcf_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0);
    endtask

    task automatic random_sequence(int n);
        int len;
        logic [31:0] b;
        logic [5:0] l;
        logic [5:0] r;
        len = $urandom_range(0, 14);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0 || n == 0)
            begin
                l = 6'($urandom);
                r = 6'($urandom);
            end
            else
            begin
                l = 6'($urandom_range(0, n - 1));
                r = 6'($urandom_range(0, n - 1));
            end
            case ($urandom_range(0, 7))
                0: b = $urandom;
                1: b = 32'h80000000 | $urandom_range(0, 3);
                2: b = 32'h7fffffff - $urandom_range(0, 3);
                default: b = $urandom_range(0, 20) - 8;
            endcase
            send_request(dcf_pkg::OP_ADD, l, r, b);
        end
        send_request(dcf_pkg::OP_EVAL, 6'($urandom), 6'($urandom), $urandom);
    endtask

    task automatic test_random();
        int n;
        logic [31:0] cap;
        while (items_sent < 1400)
        begin
            case ($urandom_range(0, 9))
                0: n = 0;
                1: n = 64;
                2: n = $urandom_range(65, 127);
                default: n = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 5))
                0: cap = 0;
                1: cap = 32'hffffffff;
                2: cap = $urandom;
                default: cap = $urandom_range(1, 5000);
            endcase
            configure(7'(n), cap);
            send_idle_off = ($urandom_range(0, 3) == 0);
            recv_idle_off = ($urandom_range(0, 3) == 0);
            for (int s = 0; s < 8; s++)
                random_sequence(n > 64 ? 64 : n);
        end
        send_idle_off = 0;
        recv_idle_off = 0;
    endtask

    task automatic test_backpressure();
        configure(7'd4, 32'd100000);
        hold_cycles = 400;
        send_idle_off = 1;
        for (int s = 0; s < 3; s++)
            random_sequence(4);
        send_idle_off = 0;
        wait_drained();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = dcf_pkg::OP_ADD;
        wr_en         = 1'b0;
        wr_index      = dcf_pkg::REG_VAR_COUNT;
        wr_data       = '0;
        failures      = 0;
        send_idle_off = 0;
        recv_idle_off = 0;
        hold_cycles   = 0;
        items_sent    = 0;
        cycle_count   = 0;
        var_count_q   = 7'd0;
        enum_cap_q    = 32'd1000000;
        cons_count    = 0;
        largest_mag   = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_values();
        test_directed();
        test_store_full();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (100) @(negedge clk);
        if (failures == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

>>> files.f
rtl/dcf_pkg.sv
rtl/difference_constraint_feasibility_unit.sv
tb/tb.sv
